/* design/checked_frame_deframer_defines.svh */
// ----------------------------------------------------------------------------
// Checked frame deframer assertion macros
// Assertion wrappers shared by the deframer modules. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define CHECKED_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge while reset is released.
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* design/cfd_pkg.sv */
// ----------------------------------------------------------------------------
// Checked frame deframer package
// Payload types, per-channel context layout, phase and result kind codes.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam logic [7:0]  START_BYTE    = 8'hF3;
    localparam logic [7:0]  END_BYTE      = 8'hF4;
    localparam logic [15:0] MAX_LEN_RESET = 16'(256 + 128);

    // Per-channel parser phase.
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HCHK = 3'd1;
    localparam logic [2:0] PH_LEN1 = 3'd2;
    localparam logic [2:0] PH_LEN2 = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM  = 3'd5;
    localparam logic [2:0] PH_END  = 3'd6;

    // Result kinds.
    localparam logic [2:0] K_ID       = 3'd0;
    localparam logic [2:0] K_PAYLOAD  = 3'd1;
    localparam logic [2:0] K_GOOD     = 3'd2;
    localparam logic [2:0] K_BAD_HCHK = 3'd3;
    localparam logic [2:0] K_BAD_LEN  = 3'd4;
    localparam logic [2:0] K_BAD_SUM  = 3'd5;
    localparam logic [2:0] K_BAD_END  = 3'd6;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] data_byte;
    } cfd_in_t;

    typedef struct packed {
        logic [1:0]  out_channel;
        logic [2:0]  kind;
        logic [7:0]  value;
        logic [15:0] item_index;
    } cfd_out_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  received_header_check;
        logic [7:0]  computed_header_check;
        logic [15:0] frame_length;
        logic [15:0] bytes_received;
        logic [7:0]  running_sum;
    } cfd_ctx_t;

    typedef struct packed {
        logic     emit;
        cfd_out_t item;
    } cfd_step_out_t;

endpackage

/* design/cfd_ctx_mem.sv */
// ----------------------------------------------------------------------------
// Checked frame deframer context memory
// One context entry per channel, registered read, write-to-read
// forwarding, and per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
module cfd_ctx_mem #(
    parameter int DEPTH = 4
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output cfd_pkg::cfd_ctx_t                         rd_ctx,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  cfd_pkg::cfd_ctx_t                         wr_ctx
);
    import cfd_pkg::*;

    cfd_ctx_t         mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    cfd_ctx_t         rd_ctx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_ctx;
        end
    end

    // A read that meets a write to the same entry takes the new context.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_ctx_reg <= wr_ctx;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_ctx_reg <= mem[rd_addr];
            end
            else
            begin
                rd_ctx_reg <= '0;
            end
        end
    end

    assign rd_ctx = rd_ctx_reg;

endmodule

/* design/cfd_step.sv */
// ----------------------------------------------------------------------------
// Checked frame deframer step logic
// Advances one channel context by one received byte and forms the result.
// ----------------------------------------------------------------------------
module cfd_step (
    input  cfd_pkg::cfd_ctx_t      cur_ctx,
    input  cfd_pkg::cfd_in_t       in_item,
    input  logic [15:0]            max_frame_length,
    output cfd_pkg::cfd_ctx_t      nxt_ctx,
    output cfd_pkg::cfd_step_out_t step_out
);
    import cfd_pkg::*;

    logic [7:0]  b;
    logic [7:0]  chc_sum;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;

    assign b        = in_item.data_byte;
    assign chc_sum  = cur_ctx.computed_header_check + b;
    assign len_full = {b, cur_ctx.frame_length[7:0]};
    assign cnt_inc  = cur_ctx.bytes_received + 16'd1;

    always_comb
    begin
        nxt_ctx                      = cur_ctx;
        step_out.emit                = 1'b0;
        step_out.item.out_channel    = in_item.channel;
        step_out.item.kind           = K_GOOD;
        step_out.item.value          = '0;
        step_out.item.item_index     = '0;

        case (cur_ctx.phase)
            PH_HCHK:
            begin
                nxt_ctx.received_header_check = b;
                nxt_ctx.phase                 = PH_LEN1;
            end
            PH_LEN1:
            begin
                nxt_ctx.computed_header_check = chc_sum;
                nxt_ctx.frame_length          = {8'h00, b};
                nxt_ctx.phase                 = PH_LEN2;
            end
            PH_LEN2:
            begin
                nxt_ctx.computed_header_check = chc_sum;
                nxt_ctx.frame_length          = len_full;
                if (cur_ctx.received_header_check != chc_sum)
                begin
                    nxt_ctx.phase      = PH_HUNT;
                    step_out.emit      = 1'b1;
                    step_out.item.kind = K_BAD_HCHK;
                end
                else if ((len_full == 16'd0) || (len_full > max_frame_length))
                begin
                    nxt_ctx.phase      = PH_HUNT;
                    step_out.emit      = 1'b1;
                    step_out.item.kind = K_BAD_LEN;
                end
                else
                begin
                    nxt_ctx.phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                nxt_ctx.running_sum    = cur_ctx.running_sum + b;
                nxt_ctx.bytes_received = cnt_inc;
                if (cnt_inc == cur_ctx.frame_length)
                begin
                    nxt_ctx.phase = PH_SUM;
                end
                step_out.emit            = 1'b1;
                step_out.item.kind       = (cur_ctx.bytes_received == 16'd0) ? K_ID : K_PAYLOAD;
                step_out.item.value      = b;
                step_out.item.item_index = cur_ctx.bytes_received;
            end
            PH_SUM:
            begin
                if (cur_ctx.running_sum != b)
                begin
                    nxt_ctx.phase      = PH_HUNT;
                    step_out.emit      = 1'b1;
                    step_out.item.kind = K_BAD_SUM;
                end
                else
                begin
                    nxt_ctx.phase = PH_END;
                end
            end
            PH_END:
            begin
                nxt_ctx.phase      = PH_HUNT;
                step_out.emit      = 1'b1;
                step_out.item.kind = (b == END_BYTE) ? K_GOOD : K_BAD_END;
            end
            default:
            begin
                // Hunting, and also any unused phase code.
                if (b == START_BYTE)
                begin
                    nxt_ctx                       = '0;
                    nxt_ctx.computed_header_check = START_BYTE;
                    nxt_ctx.phase                 = PH_HCHK;
                end
                else
                begin
                    nxt_ctx.phase = PH_HUNT;
                end
            end
        endcase
    end

endmodule

/* design/checked_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Checked frame deframer
// Bytes enter on byte_valid/byte_ready with their channel; results leave on
// result_valid/result_ready. Each channel keeps its own frame context in a
// small context memory, so bytes of different channels may interleave freely.
// An accepted byte reads its channel context (registered memory read), is
// processed in the next cycle and written back; its result is registered in
// the output register. A byte following on the same channel gets the updated
// context by forwarding, so one byte per cycle is sustained while results are
// taken. Bytes whose channel is CHANNELS or higher are dropped silently.
// Reset returns every channel to hunting and max_frame_length to 384.
// When the receiver stalls, one result waits in the output register; the
// byte behind it still completes if it produces no result, otherwise it
// holds and byte_ready falls until the output register drains.
// ----------------------------------------------------------------------------
module checked_frame_deframer #(
    parameter int CHANNELS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  cfd_pkg::cfd_in_t   byte_data,
    output logic               result_valid,
    input  logic               result_ready,
    output cfd_pkg::cfd_out_t  result_data
);
    import cfd_pkg::*;

`include "checked_frame_deframer_defines.svh"

    localparam int         ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIM = 5'(CHANNELS);

    logic [15:0]   max_len_reg;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    cfd_in_t       s1_item_reg;
    logic          res_valid_reg;
    cfd_out_t      res_data_reg;

    logic          accept;
    logic          in_range;
    logic          s1_stall;
    logic          s1_fire;
    cfd_ctx_t      cur_ctx;
    cfd_ctx_t      nxt_ctx;
    cfd_step_out_t step_out;

    assign in_range   = ({3'b000, byte_data.channel} < CH_LIM);
    assign s1_stall   = s1_valid_reg && step_out.emit && res_valid_reg && !result_ready;
    assign s1_fire    = s1_valid_reg && !s1_stall;
    assign byte_ready = !s1_stall;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = in_range;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    cfd_ctx_mem #(
        .DEPTH (CHANNELS)
    ) u_ctx_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (ADDR_W'(byte_data.channel)),
        .rd_ctx  (cur_ctx),
        .wr_en   (s1_fire),
        .wr_addr (ADDR_W'(s1_item_reg.channel)),
        .wr_ctx  (nxt_ctx)
    );

    cfd_step u_step (
        .cur_ctx          (cur_ctx),
        .in_item          (s1_item_reg),
        .max_frame_length (max_len_reg),
        .nxt_ctx          (nxt_ctx),
        .step_out         (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s1_valid_next;
            if (s1_fire && step_out.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= byte_data;
        end
        if (s1_fire && step_out.emit)
        begin
            res_data_reg <= step_out.item;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

    `CFD_ASSERT(a_stall_holds_item, clk, rst_n,
        s1_stall |=> (s1_valid_reg && $stable(s1_item_reg)),
        "stalled byte lost its place in the processing stage")
    `CFD_ASSERT(a_no_overwrite, clk, rst_n,
        (s1_fire && step_out.emit) |-> (!res_valid_reg || result_ready),
        "result written over one not yet taken")
    `CFD_ASSERT(a_accept_loads_stage, clk, rst_n,
        (accept && in_range) |=> s1_valid_reg,
        "accepted in-range byte did not enter the processing stage")
    `CFD_ASSERT(a_out_of_range_dropped, clk, rst_n,
        (accept && !in_range) |=> !s1_valid_reg,
        "byte of an absent channel entered the processing stage")

endmodule

/* bench/tb_checked_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Checked frame deframer testbench
// Feeds framed byte streams on all four channels, interleaved at random, and
// checks every result against a per-channel frame parser kept in the bench.
// Runs directed frames for each accept and reject path, then random traffic
// under several length limits, with random idle gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_checked_frame_deframer;
    import cfd_pkg::*;

    localparam int NUM_CHANNELS   = 4;
    localparam int MAX_GAP        = 18;
    localparam int PIPE_SLACK     = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum {
        FAULT_NONE,
        FAULT_HCHK,
        FAULT_LEN,
        FAULT_SUM,
        FAULT_END,
        FAULT_NOISE
    } frame_fault_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        byte_valid;
    logic        byte_ready;
    cfd_in_t     byte_data;
    logic        result_valid;
    logic        result_ready;
    cfd_out_t    result_data;

    // Parser state mirrored per channel, plus the active length limit.
    cfd_ctx_t    frame_ctx [NUM_CHANNELS];
    logic [15:0] max_len;
    cfd_out_t    pending_results [$];
    logic [7:0]  byte_plan [NUM_CHANNELS][$];

    logic        tx_idle_on;
    logic        rx_idle_on;
    int unsigned bytes_sent;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned limits_used;
    int unsigned stall_cycles;
    int unsigned kind_seen [7];

    always #2 clk = ~clk;

    checked_frame_deframer #(
        .CHANNELS(NUM_CHANNELS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data(byte_data),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data(result_data)
    );

    function automatic void deframe_byte(logic [1:0] ch, logic [7:0] b);
        cfd_ctx_t    c;
        cfd_out_t    r;
        logic        emit;
        logic [15:0] idx;
        c = frame_ctx[ch];
        r = '0;
        r.out_channel = ch;
        emit = 1'b0;
        case (c.phase)
            PH_HCHK:
            begin
                c.received_header_check = b;
                c.phase = PH_LEN1;
            end
            PH_LEN1:
            begin
                c.computed_header_check = c.computed_header_check + b;
                c.frame_length = {8'h00, b};
                c.phase = PH_LEN2;
            end
            PH_LEN2:
            begin
                c.computed_header_check = c.computed_header_check + b;
                c.frame_length[15:8] = b;
                // The header check takes priority over the length check.
                if (c.received_header_check != c.computed_header_check)
                begin
                    c.phase = PH_HUNT;
                    r.kind = K_BAD_HCHK;
                    emit = 1'b1;
                end
                else if (c.frame_length == 16'd0 || c.frame_length > max_len)
                begin
                    c.phase = PH_HUNT;
                    r.kind = K_BAD_LEN;
                    emit = 1'b1;
                end
                else
                begin
                    c.phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                idx = c.bytes_received;
                c.running_sum = c.running_sum + b;
                c.bytes_received = idx + 16'd1;
                if (c.bytes_received == c.frame_length)
                begin
                    c.phase = PH_SUM;
                end
                r.kind = (idx == 16'd0) ? K_ID : K_PAYLOAD;
                r.value = b;
                r.item_index = idx;
                emit = 1'b1;
            end
            PH_SUM:
            begin
                if (c.running_sum != b)
                begin
                    c.phase = PH_HUNT;
                    r.kind = K_BAD_SUM;
                    emit = 1'b1;
                end
                else
                begin
                    c.phase = PH_END;
                end
            end
            PH_END:
            begin
                c.phase = PH_HUNT;
                r.kind = (b == END_BYTE) ? K_GOOD : K_BAD_END;
                emit = 1'b1;
            end
            default:
            begin
                // Any unused phase code behaves like hunting.
                if (b == START_BYTE)
                begin
                    c = '0;
                    c.computed_header_check = START_BYTE;
                    c.phase = PH_HCHK;
                end
                else
                begin
                    c.phase = PH_HUNT;
                end
            end
        endcase
        frame_ctx[ch] = c;
        if (emit)
        begin
            pending_results.push_back(r);
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [1:0] ch, input logic [7:0] b);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_data <= '{channel: ch, data_byte: b};
        byte_valid <= 1'b1;
        deframe_byte(ch, b);
        bytes_sent++;
        do
        begin
            @(posedge clk);
        end
        while (!byte_ready);
        @(negedge clk);
    endtask

    // Always waits for a falling edge, so valid never falls and rises in one step.
    task automatic wait_results_drained();
        byte_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    task automatic write_max_length(input logic [15:0] limit);
        wait_results_drained();
        // Bytes that give no result may still be in the pipeline.
        repeat (PIPE_SLACK) @(negedge clk);
        cfg_wr_data <= limit;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        max_len = limit;
        limits_used++;
    endtask

    task automatic plan_frame(input int ch, input logic [15:0] len, input frame_fault_t fault);
        logic [7:0]  hc;
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned i;
        if (fault == FAULT_NOISE)
        begin
            for (i = 0; i < len; i++)
            begin
                byte_plan[ch].push_back(8'($urandom_range(0, 255)));
            end
            return;
        end
        hc = START_BYTE + len[7:0] + len[15:8];
        if (fault == FAULT_HCHK)
        begin
            hc = hc + 8'($urandom_range(1, 255));
        end
        byte_plan[ch].push_back(START_BYTE);
        byte_plan[ch].push_back(hc);
        byte_plan[ch].push_back(len[7:0]);
        byte_plan[ch].push_back(len[15:8]);
        if (fault == FAULT_HCHK || fault == FAULT_LEN)
        begin
            return;
        end
        sum = 8'h00;
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            byte_plan[ch].push_back(b);
            sum = sum + b;
        end
        if (fault == FAULT_SUM)
        begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        byte_plan[ch].push_back(sum);
        if (fault == FAULT_END)
        begin
            b = 8'($urandom_range(0, 254));
            if (b >= END_BYTE)
            begin
                b = b + 8'd1;
            end
            byte_plan[ch].push_back(b);
        end
        else
        begin
            byte_plan[ch].push_back(END_BYTE);
        end
    endtask

    task automatic send_plan(input int ch);
        while (byte_plan[ch].size() != 0)
        begin
            send_byte(2'(ch), byte_plan[ch].pop_front());
        end
    endtask

    function automatic logic [15:0] pick_good_len();
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 99);
        if (r < 10 && max_len <= 16'd64)
        begin
            return max_len;
        end
        top = (r < 75) ? 8 : 40;
        if (top > max_len)
        begin
            top = max_len;
        end
        return 16'($urandom_range(1, top));
    endfunction

    function automatic logic [15:0] pick_bad_len();
        int unsigned r;
        if (max_len == 16'hFFFF || $urandom_range(0, 2) == 0)
        begin
            return 16'd0;
        end
        r = $urandom_range(0, 2);
        if (r == 0)
        begin
            return max_len + 16'd1;
        end
        if (r == 1)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(int'(max_len) + 1, 65535));
    endfunction

    task automatic plan_random_frame(input int ch);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            plan_frame(ch, pick_good_len(), FAULT_NONE);
        else if (r < 72)
            plan_frame(ch, pick_good_len(), FAULT_HCHK);
        else if (r < 80)
            plan_frame(ch, pick_bad_len(), FAULT_LEN);
        else if (r < 87)
            plan_frame(ch, pick_good_len(), FAULT_SUM);
        else if (r < 94)
            plan_frame(ch, pick_good_len(), FAULT_END);
        else
            plan_frame(ch, 16'($urandom_range(1, 6)), FAULT_NOISE);
    endtask

    function automatic int unsigned planned_bytes();
        int unsigned n;
        n = 0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            n += byte_plan[ch].size();
        end
        return n;
    endfunction

    task automatic choose_idle_mode();
        logic [1:0] m;
        m = 2'($urandom_range(0, 3));
        tx_idle_on = m[0];
        rx_idle_on = m[1];
    endtask

    // Frames for each accept and reject path, run one after another under the reset limit.
    task automatic test_directed_frames();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_byte(2'd0, 8'h00);
        send_byte(2'd3, 8'hFF);
        plan_frame(0, 16'd1, FAULT_NONE);
        send_plan(0);
        // Bad header check together with a zero length.
        plan_frame(1, 16'd0, FAULT_HCHK);
        send_plan(1);
        plan_frame(2, 16'd0, FAULT_LEN);
        send_plan(2);
        plan_frame(3, max_len + 16'd1, FAULT_LEN);
        send_plan(3);
        plan_frame(0, 16'd1, FAULT_SUM);
        send_plan(0);
        plan_frame(1, 16'd1, FAULT_END);
        send_plan(1);
    endtask

    task automatic test_smallest_limit();
        write_max_length(16'd1);
        plan_frame(2, 16'd1, FAULT_NONE);
        send_plan(2);
        plan_frame(3, 16'd2, FAULT_LEN);
        send_plan(3);
    endtask

    task automatic test_largest_limit();
        write_max_length(16'hFFFF);
        plan_frame(1, 16'd0, FAULT_LEN);
        send_plan(1);
        plan_frame(0, 16'h0102, FAULT_NONE);
        send_plan(0);
    endtask

    // Interleaves planned frames across channels, then finishes every open plan.
    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned sent;
        int          ch;
        sent = 0;
        while (sent < n_bytes || planned_bytes() != 0)
        begin
            if (sent % 64 == 0)
            begin
                choose_idle_mode();
            end
            ch = $urandom_range(0, NUM_CHANNELS - 1);
            if (byte_plan[ch].size() == 0)
            begin
                if (sent >= n_bytes)
                begin
                    continue;
                end
                plan_random_frame(ch);
            end
            send_byte(2'(ch), byte_plan[ch].pop_front());
            sent++;
            if ($urandom_range(0, 199) == 0)
            begin
                wait_results_drained();
            end
        end
    endtask

    task automatic note_mismatch(input string what, input cfd_out_t exp, input cfd_out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("Mismatch (%s): expected ch=%0d kind=%0d value=%02h index=%0d,",
                     what, exp.out_channel, exp.kind, exp.value, exp.item_index);
            $display("    got ch=%0d kind=%0d value=%02h index=%0d",
                     got.out_channel, got.kind, got.value, got.item_index);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cfd_out_t exp;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (result_data.kind <= K_BAD_END)
            begin
                kind_seen[result_data.kind]++;
            end
            if (pending_results.size() == 0)
            begin
                note_mismatch("no result was due", '0, result_data);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (result_data.out_channel !== exp.out_channel
                    || result_data.kind !== exp.kind
                    || result_data.value !== exp.value
                    || result_data.item_index !== exp.item_index)
                begin
                    note_mismatch("field differs", exp, result_data);
                end
            end
        end
    end

    // When idle gaps are on, the result side holds result_ready low for a random gap before each transaction.
    initial
    begin : result_sink
        int unsigned stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(result_valid && result_ready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && byte_ready) || (result_valid && result_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     stall_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        byte_valid = 1'b0;
        byte_data = '0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        bytes_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        limits_used = 1;
        stall_cycles = 0;
        max_len = MAX_LEN_RESET;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            frame_ctx[ch] = '0;
        end
        foreach (kind_seen[k])
        begin
            kind_seen[k] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_random_traffic(200);
        test_smallest_limit();
        test_random_traffic(100);
        test_largest_limit();
        test_random_traffic(150);
        write_max_length(16'($urandom_range(2, 64)));
        test_random_traffic(125);

        wait_results_drained();
        repeat (PIPE_SLACK * 2) @(negedge clk);

        $display("Sent %0d bytes on %0d channels under %0d length limits; checked %0d results.",
                 bytes_sent, NUM_CHANNELS, limits_used, results_checked);
        $display("Frame outcomes: %0d good, %0d bad header, %0d bad length, %0d bad sum, %0d bad end.",
                 kind_seen[K_GOOD], kind_seen[K_BAD_HCHK], kind_seen[K_BAD_LEN],
                 kind_seen[K_BAD_SUM], kind_seen[K_BAD_END]);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
